FILE: src/spq_pkg.sv
// Package for the sorted priority queue: shared field widths, status and
// kind codes, and the structs passed between the top level and the cells.
// No dependencies.
package spq_pkg;

   localparam int KEY_W      = 32;
   localparam int TAG_W      = 16;
   localparam int POS_W      = 4;
   localparam int CNT_OUT_W  = 5;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 56;

   typedef enum logic [0:0] {
      KIND_INSERT = 1'b0,
      KIND_REMOVE = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_NO_ENTRY = 2'd2
   } status_type;

   // Contents of one slot of the row.
   typedef struct packed {
      logic             valid;
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
   } slot_type;

   // Operation broadcast to every cell; ins and rem are already qualified.
   typedef struct packed {
      logic             ins;
      logic             rem;
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
      logic [POS_W-1:0] position;
   } cell_cmd_type;

endpackage

FILE: src/spq_cell.sv
// One slot of the sorted row: holds a key and tag, shifts up on insert and
// down on remove, and offers its contents when its rank is removed.
// Depends on spq_pkg.
module spq_cell #(
   parameter int INDEX = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  spq_pkg::cell_cmd_type cmd,
   input  spq_pkg::slot_type    prev_slot,
   input  logic                 prev_gt,
   input  spq_pkg::slot_type    next_slot,
   output spq_pkg::slot_type    slot,
   output logic                 gt,
   output spq_pkg::slot_type    pick
);
   import spq_pkg::*;

   logic             valid_ff, valid_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [TAG_W-1:0] tag_ff, tag_in;
   logic             at_rank;
   logic             above_rank;

   // An empty slot or a strictly larger key lets the new entry in here.
   assign gt         = !valid_ff || (key_ff > cmd.key);
   assign at_rank    = (INDEX == int'(cmd.position));
   assign above_rank = (INDEX >= int'(cmd.position));

   assign slot.valid = valid_ff;
   assign slot.key   = key_ff;
   assign slot.tag   = tag_ff;

   assign pick.valid = cmd.rem && at_rank;
   assign pick.key   = (cmd.rem && at_rank) ? key_ff : '0;
   assign pick.tag   = (cmd.rem && at_rank) ? tag_ff : '0;

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      tag_in   = tag_ff;
      if (cmd.ins) begin
         if (prev_gt) begin
            valid_in = prev_slot.valid;
            key_in   = prev_slot.key;
            tag_in   = prev_slot.tag;
         end else if (gt) begin
            valid_in = 1'b1;
            key_in   = cmd.key;
            tag_in   = cmd.tag;
         end
      end else if (cmd.rem && above_rank) begin
         valid_in = next_slot.valid;
         key_in   = next_slot.key;
         tag_in   = next_slot.tag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      key_ff <= key_in;
      tag_ff <= tag_in;
   end

endmodule

FILE: src/sorted_priority_queue.sv
// Sorted priority queue, top level: a row of DEPTH cells kept in ascending
// key order, an entry counter and a one-deep result register.
// Depends on spq_pkg and spq_cell.
//
// Usage: every request transfer yields exactly one response transfer. An
// insert (tuser = 0) places its key after all stored entries with an equal
// or smaller key, so equal keys leave in arrival order; a remove (tuser = 1)
// takes out the entry at the given rank, rank 0 holding the smallest key,
// and returns its key and tag. Each cell compares its own key against the
// incoming one and shifts toward its neighbor in the same edge, so the block
// takes one request per cycle unless back-pressure holds the response, and
// the response appears in the cycle after the request transfer. The single
// result register sets the rate under back-pressure: a new request is taken
// while the held response is being taken in the same cycle. An insert into a
// full queue and a remove at an unoccupied rank change nothing and report it
// in the status. Every response carries the entry count after the request.
module sorted_priority_queue #(
   parameter int DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [31:0] entry_freq, [47:32] entry_tag, [51:48] position, [55:52] zero
   input  logic [spq_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [0] kind
   input  logic                              req_tuser,
   // Response channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [31:0] removed_freq, [47:32] removed_tag, [52:48] entry_count, [55:53] zero
   output logic [spq_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // [1:0] status
   output logic [1:0]                        rsp_tuser
);
   import spq_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;

   logic                  accept;
   logic                  is_insert;
   logic                  full;
   logic                  rank_ok;
   status_type            status;
   cell_cmd_type          cmd;

   slot_type              slots [DEPTH];
   slot_type              picks [DEPTH];
   logic                  gts   [DEPTH];
   slot_type              picked;

   // Take a new request whenever the result register is empty or draining.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign is_insert  = (kind_type'(req_tuser) == KIND_INSERT);
   assign full       = (count_ff == CNT_W'(DEPTH));
   assign rank_ok    = (CMP_W'(req_tdata[51:48]) < CMP_W'(count_ff));

   // Broadcast the qualified operation to the row.
   assign cmd.ins      = accept && is_insert && !full;
   assign cmd.rem      = accept && !is_insert && rank_ok;
   assign cmd.key      = req_tdata[31:0];
   assign cmd.tag      = req_tdata[47:32];
   assign cmd.position = req_tdata[51:48];

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         slot_type prev_s;
         slot_type next_s;
         logic     prev_g;

         if (gi == 0) begin : g_head
            assign prev_s = '0;
            assign prev_g = 1'b0;
         end else begin : g_body
            assign prev_s = slots[gi-1];
            assign prev_g = gts[gi-1];
         end

         // Shift an empty slot into the tail on remove.
         if (gi == DEPTH - 1) begin : g_tail
            assign next_s = '0;
         end else begin : g_inner
            assign next_s = slots[gi+1];
         end

         spq_cell #(
            .INDEX(gi)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .cmd       (cmd),
            .prev_slot (prev_s),
            .prev_gt   (prev_g),
            .next_slot (next_s),
            .slot      (slots[gi]),
            .gt        (gts[gi]),
            .pick      (picks[gi])
         );
      end
   endgenerate

   // Merge the removed entry; at most one cell offers a nonzero pick.
   always_comb begin
      picked = '0;
      for (int i = 0; i < DEPTH; i++) begin
         picked = picked | picks[i];
      end
   end

   always_comb begin
      count_in = count_ff;
      status   = STATUS_OK;
      if (accept) begin
         if (is_insert) begin
            if (full) begin
               status = STATUS_FULL;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end else begin
            if (rank_ok) begin
               count_in = count_ff - CNT_W'(1);
            end else begin
               status = STATUS_NO_ENTRY;
            end
         end
      end
   end

   // Load the result register on accept, drop it once taken.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      if (accept) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status;
         rsp_data_in   = '0;
         rsp_data_in[31:0]  = cmd.rem ? picked.key : '0;
         rsp_data_in[47:32] = cmd.rem ? picked.tag : '0;
         rsp_data_in[52:48] = CNT_OUT_W'(count_in);
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule
